// ===== rtl/tqls_pkg.sv =====
// Shared widths, register codes, reset values and types of the tree Q-learning step block.
package tqls_pkg;

  localparam int Q_W     = 10;
  localparam int FRAC_W  = 16;
  localparam int NODE_W  = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: 17 bit unsigned-as-signed by 27 bit signed.
  localparam int MUL_B_W = 27;
  localparam int MUL_P_W = FRAC_W + 1 + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_NODE  = 3'd4;

  localparam logic [FRAC_W-1:0] LEARN_RATE_RST   = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST     = 16'd58982;
  localparam logic [FRAC_W-1:0] EXPLORE_RST      = 16'd19661;
  localparam logic [Q_W-1:0]    REWARD_VALUE_RST = 10'd1000;
  localparam logic [NODE_W-1:0] REWARD_NODE_RST  = 4'd14;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic [FRAC_W-1:0] learn_rate;
    logic [FRAC_W-1:0] discount;
    logic [FRAC_W-1:0] explore_threshold;
    logic [Q_W-1:0]    reward_value;
    logic [NODE_W-1:0] reward_node;
  } cfg_regs_t;

endpackage

// ===== rtl/tqls_ifs.sv =====
// Request and result channel interfaces of the tree Q-learning step block.
interface tqls_item_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [tqls_pkg::NODE_W-1:0] load_index;
  logic [tqls_pkg::Q_W-1:0]    load_value;
  logic [tqls_pkg::FRAC_W-1:0] chance;
  logic                        direction;

  modport source (output valid, kind, load_index, load_value, chance, direction,
                  input ready);
  modport sink (input valid, kind, load_index, load_value, chance, direction,
                output ready);
endinterface

interface tqls_result_if;
  logic                        valid;
  logic                        ready;
  logic [tqls_pkg::NODE_W-1:0] node;
  logic [tqls_pkg::Q_W-1:0]    new_q;
  logic                        episode_done;

  modport source (output valid, node, new_q, episode_done, input ready);
  modport sink (input valid, node, new_q, episode_done, output ready);
endinterface

// ===== rtl/tree_q_learning_step_top.sv =====
// Top level of the tree Q-learning step block: sequencer, Q table and update path.
//
// Usage
//   items   : request channel (valid/ready). kind 0 loads one Q-table entry,
//             kind 1 takes one epsilon-greedy step down the binary tree.
//   results : one result per request: node, stored Q value, episode_done.
//   write_en/write_index/write_data : configuration writes, taken at any edge
//             with write_en high; write only while no request is in flight.
// Timing
//   items.ready is high only while the sequencer is idle and rst is low.
//   A load goes from idle straight to write-back, where the result register is loaded;
//   an inner-node step first passes S_RIGHT, S_PICK, S_CHILD_A, S_CHILD_B, S_GAMMA,
//   S_ALPHA; a leaf step skips S_CHILD_B and S_GAMMA. The states are set by the single
//   RAM read port (two child reads, the chosen node, its two children) and by the
//   one multiplier used twice in turn (gamma * max child, then alpha * difference).
//   A finished result sits in the output register; the next request is taken
//   meanwhile, and the sequencer only waits at write-back if that register is
//   still full because the receiver stalls.
// Reset
//   rst (synchronous) restores the register defaults, marks every table entry
//   as never written (reads as zero), and puts the walk at the root.
module tree_q_learning_step_top #(
  parameter int TREE_DEPTH = 3,
  parameter int NODE_COUNT = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  tqls_item_if.sink                      items,
  tqls_result_if.source                  results,
  input  logic                           write_en,
  input  logic [tqls_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [tqls_pkg::CFG_W-1:0]     write_data
);

  localparam int IDX_W      = TREE_DEPTH + 1;          // any node index met in a step
  localparam int CUR_W      = TREE_DEPTH;              // current node is always inner
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int SC_W       = $clog2(TREE_DEPTH + 1);
  localparam int LEAF_FIRST = (2 ** TREE_DEPTH) - 1;
  localparam int Q_W        = tqls_pkg::Q_W;
  localparam int T_W        = Q_W + tqls_pkg::FRAC_W;  // target, 16 fraction bits
  localparam int P_W        = tqls_pkg::MUL_P_W;
  localparam int TOT_W      = P_W + 1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RIGHT   = 9'b000000010,
    S_PICK    = 9'b000000100,
    S_CHILD_A = 9'b000001000,
    S_CHILD_B = 9'b000010000,
    S_GAMMA   = 9'b000100000,
    S_ALPHA   = 9'b001000000,
    S_WRITE   = 9'b010000000,
    S_SPARE   = 9'b100000000
  } state_t;

  tqls_pkg::cfg_regs_t cfg;

  state_t state, state_next;

  // walk state
  logic [CUR_W-1:0] current_node;
  logic [SC_W-1:0]  step_count;

  // latched request
  logic                        req_kind;
  logic [tqls_pkg::NODE_W-1:0] req_index;
  logic [Q_W-1:0]              req_value;
  logic                        req_explore;
  logic                        req_dir;

  // step working registers
  logic [IDX_W-1:0] sel_node, sel_node_next;
  logic [Q_W-1:0]   q_left, q_sel, q_child_a;

  // table read path
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_ok;
  logic [Q_W-1:0]    ram_rdata, q_rd;
  logic [NODE_COUNT-1:0] written;

  // table write path
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [Q_W-1:0]    wr_data;

  // shared multiplier
  logic                              mul_en;
  logic [tqls_pkg::FRAC_W-1:0]       mul_a;
  logic signed [tqls_pkg::MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]             mul_p;

  // output register
  logic                        out_valid;
  logic [tqls_pkg::NODE_W-1:0] out_node;
  logic [Q_W-1:0]              out_q;
  logic                        out_done;

  logic [IDX_W-1:0] left_idx, right_idx, child_a_idx, child_b_idx;
  logic             sel_leaf, sel_reward, sel_in_table, load_in_table;
  logic [Q_W-1:0]   q_max;
  logic [T_W-1:0]   target;
  logic signed [tqls_pkg::MUL_B_W-1:0] diff;
  logic signed [TOT_W-1:0] total;
  logic [Q_W-1:0]   new_q;
  logic             out_free, wb_go, accept;
  logic [SC_W-1:0]  sc_inc;
  logic             ep_done;

  tqls_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .regs        (cfg)
  );

  tqls_ram #(.WIDTH(Q_W), .DEPTH(NODE_COUNT)) u_qtab (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ADDR_W'(rd_idx)),
    .rdata (ram_rdata)
  );

  tqls_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign items.ready = (state == S_IDLE) && !rst;
  assign accept      = items.valid && items.ready;

  // Children of the current node and of the chosen node (breadth-first numbering).
  assign left_idx    = IDX_W'({current_node, 1'b1});
  assign right_idx   = IDX_W'({current_node, 1'b0}) + IDX_W'(2);
  assign child_a_idx = IDX_W'({sel_node[CUR_W-1:0], 1'b1});
  assign child_b_idx = IDX_W'({sel_node[CUR_W-1:0], 1'b0}) + IDX_W'(2);

  assign sel_leaf      = 32'(sel_node) >= LEAF_FIRST;
  assign sel_reward    = 32'(sel_node) == 32'(cfg.reward_node);
  assign sel_in_table  = 32'(sel_node) < NODE_COUNT;
  assign load_in_table = 32'(req_index) < NODE_COUNT;

  // never-written or out-of-table entries read as zero
  assign q_rd = rd_ok ? ram_rdata : '0;

  // Greedy pick: left only when strictly larger, a tie goes right.
  always_comb begin
    if (req_explore) begin
      sel_node_next = req_dir ? right_idx : left_idx;
    end else begin
      sel_node_next = (q_left > q_rd) ? left_idx : right_idx;
    end
  end

  // read address by sequencer step
  always_comb begin
    unique case (state)
      S_IDLE:    rd_idx = left_idx;
      S_RIGHT:   rd_idx = right_idx;
      S_PICK:    rd_idx = sel_node_next;
      S_CHILD_A: rd_idx = child_a_idx;
      S_CHILD_B: rd_idx = child_b_idx;
      default:   rd_idx = left_idx;
    endcase
  end

  assign q_max = (q_child_a > q_rd) ? q_child_a : q_rd;

  // Target, 16 fraction bits: gamma*max for inner, reward for the rewarded
  // leaf, the old value itself for any other leaf (which leaves it unchanged).
  always_comb begin
    if (!sel_leaf) begin
      target = mul_p[T_W-1:0];
    end else if (sel_reward) begin
      target = {cfg.reward_value, {tqls_pkg::FRAC_W{1'b0}}};
    end else begin
      target = {q_sel, {tqls_pkg::FRAC_W{1'b0}}};
    end
  end

  assign diff = $signed({1'b0, target}) - $signed({1'b0, q_sel, {tqls_pkg::FRAC_W{1'b0}}});

  // multiplier operands: first pass gamma * max, second pass alpha * diff;
  // the product is frozen from write-back on
  assign mul_en = (state == S_GAMMA) || (state == S_ALPHA);

  always_comb begin
    if (state == S_GAMMA) begin
      mul_a = cfg.discount;
      mul_b = $signed({{(tqls_pkg::MUL_B_W - Q_W){1'b0}}, q_max});
    end else begin
      mul_a = cfg.learn_rate;
      mul_b = diff;
    end
  end

  // q * 2^32 + alpha * diff, floor, clamp to the table range
  assign total = $signed({{(TOT_W - Q_W - 2 * tqls_pkg::FRAC_W){1'b0}}, q_sel,
                          {(2 * tqls_pkg::FRAC_W){1'b0}}})
               + $signed({mul_p[P_W-1], mul_p});

  always_comb begin
    if (total[TOT_W-1]) begin
      new_q = '0;
    end else if (|total[TOT_W-2:Q_W + 2 * tqls_pkg::FRAC_W]) begin
      new_q = '1;
    end else begin
      new_q = total[Q_W + 2 * tqls_pkg::FRAC_W - 1:2 * tqls_pkg::FRAC_W];
    end
  end

  assign out_free = !out_valid || results.ready;
  assign wb_go    = (state == S_WRITE) && out_free;

  assign sc_inc  = step_count + SC_W'(1);
  assign ep_done = (32'(sc_inc) >= TREE_DEPTH) || sel_leaf;

  // table write at write-back
  always_comb begin
    if (req_kind == tqls_pkg::KIND_LOAD) begin
      wr_en   = wb_go && load_in_table;
      wr_addr = ADDR_W'(req_index);
      wr_data = req_value;
    end else begin
      wr_en   = wb_go && sel_in_table;
      wr_addr = ADDR_W'(sel_node);
      wr_data = new_q;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (items.kind == tqls_pkg::KIND_LOAD) ? S_WRITE : S_RIGHT;
        end
      end
      S_RIGHT:   state_next = S_PICK;
      S_PICK:    state_next = S_CHILD_A;
      S_CHILD_A: state_next = sel_leaf ? S_ALPHA : S_CHILD_B;
      S_CHILD_B: state_next = S_GAMMA;
      S_GAMMA:   state_next = S_ALPHA;
      S_ALPHA:   state_next = S_WRITE;
      S_WRITE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read qualifier travels with the registered RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= (32'(rd_idx) < NODE_COUNT) && written[ADDR_W'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // request latch and step working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind    <= items.kind;
      req_index   <= items.load_index;
      req_value   <= items.load_value;
      req_explore <= items.chance < cfg.explore_threshold;
      req_dir     <= items.direction;
    end
    if (state == S_RIGHT) begin
      q_left <= q_rd;
    end
    if (state == S_PICK) begin
      sel_node <= sel_node_next;
    end
    if (state == S_CHILD_A) begin
      q_sel <= q_rd;
    end
    if (state == S_CHILD_B) begin
      q_child_a <= q_rd;
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      current_node <= '0;
      step_count   <= '0;
    end else if (wb_go && (req_kind == tqls_pkg::KIND_STEP)) begin
      if (ep_done) begin
        current_node <= '0;
        step_count   <= '0;
      end else begin
        current_node <= sel_node[CUR_W-1:0];
        step_count   <= sc_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_go) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      if (req_kind == tqls_pkg::KIND_LOAD) begin
        out_node <= req_index;
        out_q    <= load_in_table ? req_value : '0;
        out_done <= 1'b0;
      end else begin
        out_node <= tqls_pkg::NODE_W'(sel_node);
        out_q    <= new_q;
        out_done <= ep_done;
      end
    end
  end

  assign results.valid        = out_valid;
  assign results.node         = out_node;
  assign results.new_q        = out_q;
  assign results.episode_done = out_done;

endmodule

// ===== rtl/tqls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tqls_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tqls_cfg.sv =====
// Configuration register file: learn rate, discount, explore threshold, reward.
module tqls_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_en,
  input  logic [tqls_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [tqls_pkg::CFG_W-1:0]     write_data,
  output tqls_pkg::cfg_regs_t            regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.learn_rate        <= tqls_pkg::LEARN_RATE_RST;
      regs.discount          <= tqls_pkg::DISCOUNT_RST;
      regs.explore_threshold <= tqls_pkg::EXPLORE_RST;
      regs.reward_value      <= tqls_pkg::REWARD_VALUE_RST;
      regs.reward_node       <= tqls_pkg::REWARD_NODE_RST;
    end else if (write_en) begin
      unique case (write_index)
        tqls_pkg::CFG_LEARN_RATE:   regs.learn_rate        <= write_data;
        tqls_pkg::CFG_DISCOUNT:     regs.discount          <= write_data;
        tqls_pkg::CFG_EXPLORE:      regs.explore_threshold <= write_data;
        tqls_pkg::CFG_REWARD_VALUE: regs.reward_value      <= write_data[tqls_pkg::Q_W-1:0];
        tqls_pkg::CFG_REWARD_NODE:  regs.reward_node       <= write_data[tqls_pkg::NODE_W-1:0];
        default: ; // indexes past the list are ignored
      endcase
    end
  end

endmodule

// ===== rtl/tqls_mul.sv =====
// Shared registered multiplier: unsigned 0.16 fraction times signed operand.
module tqls_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [tqls_pkg::FRAC_W-1:0]           a,
  input  logic signed [tqls_pkg::MUL_B_W-1:0]   b,
  output logic signed [tqls_pkg::MUL_P_W-1:0]   p
);

  logic signed [tqls_pkg::FRAC_W:0]    a_s;
  logic signed [tqls_pkg::MUL_P_W-1:0] p_comb;

  assign a_s    = $signed({1'b0, a});
  assign p_comb = a_s * b;

  // product holds while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_comb;
    end
  end

endmodule
